// File: design/pvie_pkg.sv
`timescale 1ns / 1ps

package pvie_pkg;

    localparam int NUM_AXES = 3;
    localparam int COORD_W  = 32;
    localparam int SIZE_W   = 31;
    localparam int IDX_BITS = 14;               // width of one grid extent
    localparam int CFG_W    = NUM_AXES * IDX_BITS;
    localparam int CODE_W   = 32;

    // 1: Q16.16 coordinates divided by the voxel size; 0: integer indices.
    localparam bit RAW_POINTS = 1'b1;

    localparam int SHIFT_NARROW = 8;
    localparam int SHIFT_WIDE   = 11;

    localparam logic [CODE_W-1:0] CODE_INVALID = 32'hBF80_0000;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 31'd65536;

    typedef enum logic [2:0] {
        CFG_GRID_BOUNDS,
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_ORDER_XYZ
    } t_cfg_reg;

    // One axis in flight through the divider chain.
    typedef struct packed {
        logic [SIZE_W-1:0]   rem;   // partial remainder, below the size unless the lane is bad
        logic [IDX_BITS-1:0] low;   // dividend bits not yet shifted in
        logic [IDX_BITS-1:0] quo;   // quotient bits found so far
        logic                bad;   // already known to be out of grid
    } t_lane;

    // lane 0 is x, 1 is y, 2 is z
    typedef t_lane [NUM_AXES-1:0]                t_beat;
    typedef logic  [NUM_AXES-1:0][SIZE_W-1:0]    t_sizes;
    typedef logic  [NUM_AXES-1:0][COORD_W-1:0]   t_coords;

endpackage

// File: design/point_voxel_index_encoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Beat contents
// input     in         i_valid/o_stall   i_coord_x, i_coord_y, i_coord_z
// output    out        o_valid/i_stall   o_voxel_code, o_in_grid
// config    in         i_cfg_we          i_cfg_addr, i_cfg_data
//
// One point per cycle sustained while the output is not stalled; stages: front
// stage, 14 divider cells, one bit of the quotient each, and the packing stage.
// Reset clears all stage valids and loads the register defaults.
// Stages advance independently, so bubbles close up under output stall;
// o_stall rises only when every stage holds a beat.
module point_voxel_index_encoder #(
    parameter bit RAW_POINTS = pvie_pkg::RAW_POINTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_coord_x,
    input  logic signed [31:0]          i_coord_y,
    input  logic signed [31:0]          i_coord_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_voxel_code,
    output logic                        o_in_grid,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_addr,
    input  logic [pvie_pkg::CFG_W-1:0]  i_cfg_data
);
    import pvie_pkg::*;

    localparam int LAST = IDX_BITS + 1;  // index of the packing stage

    logic [CFG_W-1:0]   r_bounds;
    t_coords            r_origin;
    t_sizes             r_size;
    logic               r_order_xyz;

    t_sizes             w_div_size;
    t_coords            w_coord;
    t_beat              w_beat [IDX_BITS+1];
    logic [IDX_BITS:0]  w_vld;
    logic [LAST:0]      w_load;
    logic [CODE_W-1:0]  w_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds    <= '0;
            r_origin    <= '0;
            r_size      <= {NUM_AXES{SIZE_RESET}};
            r_order_xyz <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_GRID_BOUNDS: r_bounds    <= i_cfg_data;
                CFG_ORIGIN_X:    r_origin[0] <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:    r_origin[1] <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Z:    r_origin[2] <= i_cfg_data[COORD_W-1:0];
                CFG_SIZE_X:      r_size[0]   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:      r_size[1]   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:      r_size[2]   <= i_cfg_data[SIZE_W-1:0];
                CFG_ORDER_XYZ:   r_order_xyz <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // index mode divides by one
    assign w_div_size = RAW_POINTS ? r_size : {NUM_AXES{SIZE_W'(1)}};
    assign w_coord    = {i_coord_z, i_coord_y, i_coord_x};

    // a stage loads when it is empty or its successor loads
    always_comb begin
        w_load[LAST] = !o_valid || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_load[k] = !w_vld[k] || w_load[k+1];
        end
    end

    assign o_stall = !w_load[0];

    pvie_front #(
        .RAW_POINTS (RAW_POINTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load[0]),
        .i_valid  (i_valid),
        .i_coord  (w_coord),
        .i_origin (r_origin),
        .i_size   (w_div_size),
        .o_valid  (w_vld[0]),
        .o_beat   (w_beat[0])
    );

    for (genvar k = 0; k < IDX_BITS; k++) begin : g_cell
        pvie_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[k+1]),
            .i_valid (w_vld[k]),
            .i_beat  (w_beat[k]),
            .i_size  (w_div_size),
            .o_valid (w_vld[k+1]),
            .o_beat  (w_beat[k+1])
        );
    end

    pvie_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load[LAST]),
        .i_valid     (w_vld[IDX_BITS]),
        .i_beat      (w_beat[IDX_BITS]),
        .i_bounds    (r_bounds),
        .i_order_xyz (r_order_xyz),
        .o_valid     (o_valid),
        .o_code      (w_code),
        .o_in_grid   (o_in_grid)
    );

    assign o_voxel_code = $signed(w_code);

    a_invalid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_grid |-> w_code == CODE_INVALID)
        else $error("out-of-grid beat without invalid code");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&w_vld) && o_valid && i_stall)
        else $error("input stalled while the pipe has a free stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid && (w_vld == '0))
        else $error("stage valid set right after reset");

endmodule

// File: design/pvie_front.sv
`timescale 1ns / 1ps

module pvie_front #(
    parameter bit RAW_POINTS = pvie_pkg::RAW_POINTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_valid,
    input  pvie_pkg::t_coords i_coord,
    input  pvie_pkg::t_coords i_origin,
    input  pvie_pkg::t_sizes  i_size,
    output logic              o_valid,
    output pvie_pkg::t_beat   o_beat
);
    import pvie_pkg::*;

    logic  r_valid;
    t_beat r_beat;
    t_beat n_beat;

    always_comb begin
        logic [COORD_W:0]   diff;
        logic [COORD_W-1:0] dvd;
        logic               neg;
        logic [SIZE_W-1:0]  head;
        for (int a = 0; a < NUM_AXES; a++) begin
            diff = {i_coord[a][COORD_W-1], i_coord[a]} - {i_origin[a][COORD_W-1], i_origin[a]};
            if (RAW_POINTS) begin
                dvd = diff[COORD_W-1:0];
                neg = diff[COORD_W];
            end else begin
                dvd = i_coord[a];
                neg = i_coord[a][COORD_W-1];
            end
            head = {{(SIZE_W - (COORD_W - IDX_BITS)){1'b0}}, dvd[COORD_W-1:IDX_BITS]};
            n_beat[a].rem = head;
            n_beat[a].low = dvd[IDX_BITS-1:0];
            n_beat[a].quo = '0;
            // head >= size means the quotient does not fit an extent
            n_beat[a].bad = neg || (i_size[a] == '0) || (head >= i_size[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: design/pvie_cell.sv
`timescale 1ns / 1ps

// One restoring division step for all three axes.
module pvie_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_valid,
    input  pvie_pkg::t_beat  i_beat,
    input  pvie_pkg::t_sizes i_size,
    output logic             o_valid,
    output pvie_pkg::t_beat  o_beat
);
    import pvie_pkg::*;

    logic  r_valid;
    t_beat r_beat;
    t_beat n_beat;

    always_comb begin
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] dsr;
        logic            ge;
        for (int a = 0; a < NUM_AXES; a++) begin
            trial = {i_beat[a].rem, i_beat[a].low[IDX_BITS-1]};
            dsr   = {1'b0, i_size[a]};
            ge    = trial >= dsr;
            n_beat[a].rem = ge ? SIZE_W'(trial - dsr) : trial[SIZE_W-1:0];
            n_beat[a].low = {i_beat[a].low[IDX_BITS-2:0], 1'b0};
            n_beat[a].quo = {i_beat[a].quo[IDX_BITS-2:0], ge};
            n_beat[a].bad = i_beat[a].bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: design/pvie_pack.sv
`timescale 1ns / 1ps

// Range check, packing and the output register.
module pvie_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_valid,
    input  pvie_pkg::t_beat            i_beat,
    input  logic [pvie_pkg::CFG_W-1:0] i_bounds,
    input  logic                       i_order_xyz,
    output logic                       o_valid,
    output logic [pvie_pkg::CODE_W-1:0] o_code,
    output logic                       o_in_grid
);
    import pvie_pkg::*;

    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_in_grid;
    logic [CODE_W-1:0] n_code;
    logic              n_in_grid;

    always_comb begin
        logic [CODE_W-1:0]   ix;
        logic [CODE_W-1:0]   iy;
        logic [CODE_W-1:0]   iz;
        logic [CODE_W-1:0]   packed_code;
        logic [IDX_BITS-1:0] ext;
        n_in_grid = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            // x extent sits in the top field, z in the bottom one
            ext = i_bounds[(NUM_AXES-1-a)*IDX_BITS +: IDX_BITS];
            if (i_beat[a].bad || !(i_beat[a].quo < ext)) begin
                n_in_grid = 1'b0;
            end
        end
        ix = CODE_W'(i_beat[0].quo);
        iy = CODE_W'(i_beat[1].quo);
        iz = CODE_W'(i_beat[2].quo);
        if (i_order_xyz) begin
            packed_code = (ix << (SHIFT_WIDE + SHIFT_NARROW)) + (iy << SHIFT_NARROW) + iz;
        end else begin
            packed_code = ix + (iy << SHIFT_WIDE) + (iz << (SHIFT_WIDE + SHIFT_WIDE));
        end
        n_code = n_in_grid ? packed_code : CODE_INVALID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_code    <= n_code;
            r_in_grid <= n_in_grid;
        end
    end

    assign o_valid   = r_valid;
    assign o_code    = r_code;
    assign o_in_grid = r_in_grid;

endmodule

// File: sim/voxel_code_checker.sv
`timescale 1ns / 1ps

module voxel_code_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_addr,
    input  logic [pvie_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_pt_valid,
    input  logic                        i_pt_stall,
    input  logic [31:0]                 i_coord_x,
    input  logic [31:0]                 i_coord_y,
    input  logic [31:0]                 i_coord_z,
    input  logic                        i_code_valid,
    input  logic                        i_code_stall,
    input  logic [31:0]                 i_voxel_code,
    input  logic                        i_in_grid,
    output int                          o_fail_count,
    output int                          o_pending
);
    import pvie_pkg::*;

    typedef struct packed {
        logic [31:0] idx;
        logic        ok;
    } axis_hit_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              in_grid;
    } voxel_result_t;

    // shadow of the block's registers
    logic [CFG_W-1:0]  bounds;
    logic [31:0]       org_x, org_y, org_z;
    logic [SIZE_W-1:0] sz_x, sz_y, sz_z;
    logic              order_xyz;

    voxel_result_t expected_codes[$];

    function automatic axis_hit_t locate_axis(input logic [31:0] coord,
                                              input logic [31:0] org,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic [IDX_BITS-1:0] ext);
        longint            c;
        longint            o;
        longint            span;
        longint unsigned   q;
        axis_hit_t         hit;
        c       = $signed(coord);
        o       = $signed(org);
        hit.idx = '0;
        hit.ok  = 1'b0;
        if (RAW_POINTS) begin
            span = c - o;
            if (span < 0 || sz == '0)
                return hit;
            q = span / longint'({33'd0, sz});
            // quotient saturates; never below a 14-bit extent
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
        end else begin
            if (c < 0)
                return hit;
            q = c;
        end
        hit.idx = q[31:0];
        hit.ok  = q < {50'd0, ext};
        return hit;
    endfunction

    function automatic voxel_result_t encode_point(input logic [31:0] cx,
                                                   input logic [31:0] cy,
                                                   input logic [31:0] cz);
        axis_hit_t     ax;
        axis_hit_t     ay;
        axis_hit_t     az;
        logic [31:0]   code;
        voxel_result_t res;
        ax = locate_axis(cx, org_x, sz_x, bounds[3*IDX_BITS-1:2*IDX_BITS]);
        ay = locate_axis(cy, org_y, sz_y, bounds[2*IDX_BITS-1:IDX_BITS]);
        az = locate_axis(cz, org_z, sz_z, bounds[IDX_BITS-1:0]);
        if (order_xyz)
            code = (ax.idx << (SHIFT_WIDE + SHIFT_NARROW)) + (ay.idx << SHIFT_NARROW) + az.idx;
        else
            code = ax.idx + (ay.idx << SHIFT_WIDE) + (az.idx << (2 * SHIFT_WIDE));
        if (ax.ok && ay.ok && az.ok) begin
            res.code    = code;
            res.in_grid = 1'b1;
        end else begin
            res.code    = CODE_INVALID;
            res.in_grid = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        voxel_result_t want;
        if (!i_rst_n) begin
            bounds    <= '0;
            org_x     <= '0;
            org_y     <= '0;
            org_z     <= '0;
            sz_x      <= SIZE_RESET;
            sz_y      <= SIZE_RESET;
            sz_z      <= SIZE_RESET;
            order_xyz <= 1'b1;
            expected_codes.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_GRID_BOUNDS: bounds    <= i_cfg_data;
                    CFG_ORIGIN_X:    org_x     <= i_cfg_data[31:0];
                    CFG_ORIGIN_Y:    org_y     <= i_cfg_data[31:0];
                    CFG_ORIGIN_Z:    org_z     <= i_cfg_data[31:0];
                    CFG_SIZE_X:      sz_x      <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:      sz_y      <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:      sz_z      <= i_cfg_data[SIZE_W-1:0];
                    CFG_ORDER_XYZ:   order_xyz <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_pt_valid && !i_pt_stall)
                expected_codes.push_back(encode_point(i_coord_x, i_coord_y, i_coord_z));
            if (i_code_valid && !i_code_stall) begin
                if (expected_codes.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("unexpected beat: code %h in_grid %b",
                                 i_voxel_code, i_in_grid);
                end else begin
                    want = expected_codes.pop_front();
                    if (i_voxel_code !== want.code || i_in_grid !== want.in_grid) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected code %h in_grid %b, got %h in_grid %b",
                                     want.code, want.in_grid, i_voxel_code, i_in_grid);
                    end
                end
            end
            o_pending = expected_codes.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pvie_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int POINTS_PER_PHASE = 250;
    localparam int RANDOM_PHASES    = 8;
    localparam int HOLD_CYCLES      = 400;

    typedef struct packed {
        logic [CFG_W-1:0]  bounds;
        logic [31:0]       org_x;
        logic [31:0]       org_y;
        logic [31:0]       org_z;
        logic [SIZE_W-1:0] sz_x;
        logic [SIZE_W-1:0] sz_y;
        logic [SIZE_W-1:0] sz_z;
        logic              order_xyz;
    } voxel_grid_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic signed [31:0] i_coord_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_voxel_code;
    logic               o_in_grid;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_data;

    int                 fail_count;
    int                 codes_pending;
    int                 cycle_count;
    bit                 hold_armed;
    voxel_grid_t        grid;

    point_voxel_index_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_voxel_code (o_voxel_code),
        .o_in_grid    (o_in_grid),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    voxel_code_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_pt_valid   (i_valid),
        .i_pt_stall   (o_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_code_valid (o_valid),
        .i_code_stall (i_stall),
        .i_voxel_code (o_voxel_code),
        .i_in_grid    (o_in_grid),
        .o_fail_count (fail_count),
        .o_pending    (codes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic voxel_grid_t make_grid(input logic [IDX_BITS-1:0] ex,
                                              input logic [IDX_BITS-1:0] ey,
                                              input logic [IDX_BITS-1:0] ez,
                                              input logic [31:0] ox, input logic [31:0] oy,
                                              input logic [31:0] oz,
                                              input logic [SIZE_W-1:0] sx,
                                              input logic [SIZE_W-1:0] sy,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic ord);
        voxel_grid_t g;
        g.bounds    = {ex, ey, ez};
        g.org_x     = ox;
        g.org_y     = oy;
        g.org_z     = oz;
        g.sz_x      = sx;
        g.sz_y      = sy;
        g.sz_z      = sz;
        g.order_xyz = ord;
        return g;
    endfunction

    function automatic logic [IDX_BITS-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 14'd1;
        if (r < 4)  return 14'h3FFF;
        if (r < 8)  return IDX_BITS'($urandom_range(0, 16383));
        return IDX_BITS'($urandom_range(2, 64));
    endfunction

    function automatic logic [31:0] pick_origin();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r == 2) return '0;
        if (r < 5)  return $urandom;
        return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 31'd1;
        if (r == 2) return 31'h7FFF_FFFF;
        if (r < 5)  return SIZE_W'($urandom);
        if (r < 7)  return 31'd65536;
        return SIZE_W'($urandom_range(1, 32'h0004_0000));
    endfunction

    // mostly lands inside or just past the grid; the rest is noise or just below the origin
    function automatic logic [31:0] aim_coord(input logic [31:0] org,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic [IDX_BITS-1:0] ext);
        int              r;
        longint unsigned slot;
        longint unsigned off;
        logic [63:0]     pos;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom;
        if (r == 2)
            return org - $urandom_range(1, 4096);
        if (r == 3)
            slot = 64'(ext);
        else if (r == 4)
            slot = (ext == '0) ? 64'd0 : 64'(ext - 1'b1);
        else
            slot = 64'($urandom_range(0, 32'(ext)));
        off = (sz == '0) ? 64'd0 : 64'($urandom_range(0, 32'(sz - 1'b1)));
        pos = {32'd0, org} + slot * 64'(sz) + off;
        return pos[31:0];
    endfunction

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        bit held;
        i_valid   <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do begin
            @(negedge i_clk);
            held = o_stall;
            @(posedge i_clk);
        end while (held);
    endtask

    task automatic drain_codes();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (codes_pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_reg r, input logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
    endtask

    task automatic load_grid(input voxel_grid_t g);
        grid = g;
        put_reg(CFG_GRID_BOUNDS, g.bounds);
        put_reg(CFG_ORIGIN_X, CFG_W'(g.org_x));
        put_reg(CFG_ORIGIN_Y, CFG_W'(g.org_y));
        put_reg(CFG_ORIGIN_Z, CFG_W'(g.org_z));
        put_reg(CFG_SIZE_X, CFG_W'(g.sz_x));
        put_reg(CFG_SIZE_Y, CFG_W'(g.sz_y));
        put_reg(CFG_SIZE_Z, CFG_W'(g.sz_z));
        put_reg(CFG_ORDER_XYZ, CFG_W'(g.order_xyz));
        i_cfg_we <= 1'b0;
    endtask

    task automatic feed_points(input int count);
        int burst;
        burst = $urandom_range(1, 40);
        repeat (count) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                burst = $urandom_range(1, 40);
            end
            send_point(aim_coord(grid.org_x, grid.sz_x, grid.bounds[41:28]),
                       aim_coord(grid.org_y, grid.sz_y, grid.bounds[27:14]),
                       aim_coord(grid.org_z, grid.sz_z, grid.bounds[13:0]));
            burst = burst - 1;
        end
    endtask

    // output side: stretches of differing stall density, plus one long hold
    initial begin
        bit hold_done;
        int stall_pct;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                @(posedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall_pct = 30 * $urandom_range(0, 3);
                repeat ($urandom_range(4, 80)) begin
                    @(posedge i_clk);
                    i_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    initial begin
        hold_armed = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_coord_x  <= '0;
        i_coord_y  <= '0;
        i_coord_z  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        grid = make_grid(14'd0, 14'd0, 14'd0, 32'd0, 32'd0, 32'd0,
                         SIZE_RESET, SIZE_RESET, SIZE_RESET, 1'b1);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: zero extent, nothing fits
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);

        // widest grid, lowest origin, largest voxel
        drain_codes();
        load_grid(make_grid(14'h3FFF, 14'h3FFF, 14'h3FFF, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                            1'b0));
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000);

        // origin edge, last cell, one past, below origin, saturated quotient
        drain_codes();
        load_grid(make_grid(14'd100, 14'd200, 14'd50, 32'hFFFB_0000, 32'h0000_0000,
                            32'h8000_0000, 31'd65536, 31'd32768, 31'd1, 1'b1));
        send_point(32'hFFFB_0000, 32'h0000_0000, 32'h8000_0000);
        send_point(32'hFFFA_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_point(32'h005E_FFFF, 32'h0063_FFFF, 32'h8000_0031);
        send_point(32'h005F_0000, 32'h0063_FFFF, 32'h8000_0031);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);

        // zero voxel size on one axis
        drain_codes();
        load_grid(make_grid(14'h3FFF, 14'h3FFF, 14'h3FFF, 32'd0, 32'd0, 32'd0,
                            31'd0, 31'd1, 31'd65536, 1'b0));
        send_point(32'h0001_0000, 32'h0000_0005, 32'h0003_0000);
        send_point(32'h0000_0000, 32'h0000_3FFE, 32'h3FFE_FFFF);

        // unit size: indices wrap in the packed code; highest origin
        drain_codes();
        load_grid(make_grid(14'h3FFF, 14'h3FFF, 14'h3FFF, 32'd0, 32'd0, 32'h7FFF_FFFF,
                            31'd1, 31'd1, 31'd1, 1'b0));
        send_point(32'h0000_3FFF, 32'h0000_3FFF, 32'h7FFF_FFFF);
        send_point(32'h0000_4000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_0064, 32'h0000_07FF, 32'h0000_0000);

        repeat (RANDOM_PHASES) begin
            drain_codes();
            load_grid(make_grid(pick_extent(), pick_extent(), pick_extent(),
                                pick_origin(), pick_origin(), pick_origin(),
                                pick_size(), pick_size(), pick_size(),
                                1'($urandom_range(0, 1))));
            // the long hold lands while points are being offered
            hold_armed = 1'b1;
            feed_points(POINTS_PER_PHASE);
        end

        drain_codes();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && codes_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
design/pvie_pkg.sv
design/pvie_front.sv
design/pvie_cell.sv
design/pvie_pack.sv
design/point_voxel_index_encoder.sv
sim/voxel_code_checker.sv
sim/testbench.sv
